### hdl/nce_pkg.sv
// shared types, operation codes and lookup tables of the noise channel
package nce_pkg;

	localparam int LfsrWidth   = 15;
	localparam int TimerWidth  = 12;
	localparam int LengthWidth = 8;
	localparam int LevelWidth  = 4;

	typedef enum logic [2:0] {
		OP_ENV_WRITE  = 3'd0,
		OP_MODE_WRITE = 3'd1,
		OP_LEN_WRITE  = 3'd2,
		OP_EN_WRITE   = 3'd3,
		OP_QUARTER    = 3'd4,
		OP_HALF       = 3'd5,
		OP_TIMER      = 3'd6
	} op_t;

	typedef struct packed {
		logic [LevelWidth-1:0] sample;
		logic                  length_active;
	} result_t;

	localparam logic [LevelWidth-1:0] VolumeMax = 4'd15;

	function automatic logic [TimerWidth-1:0] period_lookup(input logic [3:0] idx);
		logic [TimerWidth-1:0] val;
		case (idx)
			4'd0:    val = 12'd4;
			4'd1:    val = 12'd8;
			4'd2:    val = 12'd16;
			4'd3:    val = 12'd32;
			4'd4:    val = 12'd64;
			4'd5:    val = 12'd96;
			4'd6:    val = 12'd128;
			4'd7:    val = 12'd160;
			4'd8:    val = 12'd202;
			4'd9:    val = 12'd254;
			4'd10:   val = 12'd380;
			4'd11:   val = 12'd508;
			4'd12:   val = 12'd762;
			4'd13:   val = 12'd1016;
			4'd14:   val = 12'd2034;
			default: val = 12'd4068;
		endcase
		return val;
	endfunction

	function automatic logic [LengthWidth-1:0] length_lookup(input logic [4:0] idx);
		logic [LengthWidth-1:0] val;
		case (idx)
			5'd0:    val = 8'd10;
			5'd1:    val = 8'd254;
			5'd2:    val = 8'd20;
			5'd3:    val = 8'd2;
			5'd4:    val = 8'd40;
			5'd5:    val = 8'd4;
			5'd6:    val = 8'd80;
			5'd7:    val = 8'd6;
			5'd8:    val = 8'd160;
			5'd9:    val = 8'd8;
			5'd10:   val = 8'd60;
			5'd11:   val = 8'd10;
			5'd12:   val = 8'd14;
			5'd13:   val = 8'd12;
			5'd14:   val = 8'd26;
			5'd15:   val = 8'd14;
			5'd16:   val = 8'd12;
			5'd17:   val = 8'd16;
			5'd18:   val = 8'd24;
			5'd19:   val = 8'd18;
			5'd20:   val = 8'd48;
			5'd21:   val = 8'd20;
			5'd22:   val = 8'd96;
			5'd23:   val = 8'd22;
			5'd24:   val = 8'd192;
			5'd25:   val = 8'd24;
			5'd26:   val = 8'd72;
			5'd27:   val = 8'd26;
			5'd28:   val = 8'd16;
			5'd29:   val = 8'd28;
			5'd30:   val = 8'd32;
			default: val = 8'd30;
		endcase
		return val;
	endfunction

endpackage

### hdl/noise_channel_lfsr_envelope.sv
// top level of the noise channel: input register, channel state, output register
// an accepted item passes from the input register through the channel state into the output register
// throughput: one item per clock, sustained while the output side keeps taking
// every item produces exactly one result item, in order
// the pace is set by the single state-update pass between input and output registers
// arst_n clears all channel state (shift register to 1) and empties both stages
module noise_channel_lfsr_envelope (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] data_byte
	input  logic [2:0] s_tuser,  // [2:0] opcode
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata   // [3:0] sample, [4] length_active, [7:5] zero
);
	import nce_pkg::*;

	// input stage
	logic       valid_s1;
	op_t        op_s1;
	logic [7:0] data_s1;

	// output stage
	logic       m_valid_q;
	result_t    result_q;
	result_t    result;

	logic       advance;

	// item in stage one moves on when the output register is free or being drained
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1   <= op_t'(s_tuser);
			data_s1 <= s_tdata;
		end
	end

	// channel state advances once per item as it leaves stage one
	nce_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.op     (op_s1),
		.data   (data_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {3'b000, result_q.length_active, result_q.sample};

endmodule

### hdl/nce_core.sv
// channel state: envelope, length counter, period timer and shift register
module nce_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  nce_pkg::op_t      op,
	input  logic [7:0]        data,
	output nce_pkg::result_t  result
);
	import nce_pkg::*;

	logic [LfsrWidth-1:0]   lfsr_q, lfsr_d;
	logic [TimerWidth-1:0]  timer_q, timer_d;
	logic [TimerWidth-1:0]  reload_q, reload_d;
	logic                   short_q, short_d;
	logic                   loop_q, loop_d;
	logic                   env_en_q, env_en_d;
	logic [3:0]             period_q, period_d;
	logic                   restart_q, restart_d;
	logic [3:0]             divider_q, divider_d;
	logic [LevelWidth-1:0]  volume_q, volume_d;
	logic [LengthWidth-1:0] length_q, length_d;
	logic                   enabled_q, enabled_d;
	logic                   out_bit_q, out_bit_d;
	logic                   fb;

	always_comb begin
		lfsr_d    = lfsr_q;
		timer_d   = timer_q;
		reload_d  = reload_q;
		short_d   = short_q;
		loop_d    = loop_q;
		env_en_d  = env_en_q;
		period_d  = period_q;
		restart_d = restart_q;
		divider_d = divider_q;
		volume_d  = volume_q;
		length_d  = length_q;
		enabled_d = enabled_q;
		out_bit_d = out_bit_q;
		fb        = lfsr_q[0] ^ (short_q ? lfsr_q[6] : lfsr_q[1]);
		case (op)
			OP_ENV_WRITE: begin
				loop_d   = data[5];
				env_en_d = ~data[4];
				period_d = data[3:0];
			end
			OP_MODE_WRITE: begin
				short_d  = data[7];
				reload_d = period_lookup(data[3:0]);
			end
			OP_LEN_WRITE: begin
				if (enabled_q) begin
					length_d = length_lookup(data[7:3]);
				end
				restart_d = 1'b1;
			end
			OP_EN_WRITE: begin
				enabled_d = data[0];
				if (!data[0]) begin
					length_d = '0;
				end
			end
			OP_QUARTER: begin
				if (restart_q) begin
					restart_d = 1'b0;
					volume_d  = VolumeMax;
					divider_d = period_q;
				end else if (divider_q == 4'd0) begin
					divider_d = period_q;
					if (volume_q != '0) begin
						volume_d = volume_q - 1'b1;
					end else if (loop_q) begin
						volume_d = VolumeMax;
					end
				end else begin
					divider_d = divider_q - 1'b1;
				end
			end
			OP_HALF: begin
				if (!loop_q && length_q != '0) begin
					length_d = length_q - 1'b1;
				end
			end
			OP_TIMER: begin
				// timer is frozen while the length counter is empty
				if (length_q != '0) begin
					if (timer_q == '0) begin
						lfsr_d    = {fb, lfsr_q[LfsrWidth-1:1]};
						out_bit_d = ~lfsr_q[1];
						timer_d   = reload_q;
					end else begin
						timer_d = timer_q - 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.length_active = (length_d != '0);
		if (length_d != '0 && out_bit_d) begin
			result.sample = env_en_d ? volume_d : period_d;
		end else begin
			result.sample = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lfsr_q    <= LfsrWidth'(1);
			timer_q   <= '0;
			reload_q  <= '0;
			short_q   <= 1'b0;
			loop_q    <= 1'b0;
			env_en_q  <= 1'b0;
			period_q  <= '0;
			restart_q <= 1'b0;
			divider_q <= '0;
			volume_q  <= '0;
			length_q  <= '0;
			enabled_q <= 1'b0;
			out_bit_q <= 1'b0;
		end else if (step) begin
			lfsr_q    <= lfsr_d;
			timer_q   <= timer_d;
			reload_q  <= reload_d;
			short_q   <= short_d;
			loop_q    <= loop_d;
			env_en_q  <= env_en_d;
			period_q  <= period_d;
			restart_q <= restart_d;
			divider_q <= divider_d;
			volume_q  <= volume_d;
			length_q  <= length_d;
			enabled_q <= enabled_d;
			out_bit_q <= out_bit_d;
		end
	end

endmodule
